@@ rtl/stg_pkg.sv @@
// shared constants, request codes and period table for the step generator
package stg_pkg;

  localparam int POS_WIDTH = 32;
  localparam int PERIOD_WIDTH = 17;
  localparam int SPEED_WIDTH = 3;
  localparam int USTEP_WIDTH = 4;
  localparam int REQ_WIDTH = 3;
  localparam int OPERAND_WIDTH = 32;
  localparam int OUT_POS_WIDTH = 32;
  localparam int EXT_WIDTH = 64;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH = 4;

  localparam logic signed [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);
  localparam logic [PERIOD_WIDTH-1:0] PERIOD_ONE = PERIOD_WIDTH'(1);
  localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = PERIOD_WIDTH'(96000);

  localparam logic [REQ_WIDTH-1:0] REQ_TICK = 3'd0;
  localparam logic [REQ_WIDTH-1:0] REQ_START = 3'd1;
  localparam logic [REQ_WIDTH-1:0] REQ_STOP = 3'd2;
  localparam logic [REQ_WIDTH-1:0] REQ_SET_TARGET = 3'd3;
  localparam logic [REQ_WIDTH-1:0] REQ_SET_POS = 3'd4;
  localparam logic [REQ_WIDTH-1:0] REQ_SET_CONT = 3'd5;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPEED_MODE = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MICROSTEP = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REVERSE = 2'd2;

  localparam logic [SPEED_WIDTH-1:0] SPEED_MIN = 3'd1;
  localparam logic [SPEED_WIDTH-1:0] SPEED_MAX = 3'd5;
  localparam logic [SPEED_WIDTH-1:0] SPEED_RESET = 3'd1;

  function automatic logic [PERIOD_WIDTH-1:0] base_period(input logic [SPEED_WIDTH-1:0] mode);
    logic [PERIOD_WIDTH-1:0] p;
    case (mode)
      3'd1:    p = PERIOD_WIDTH'(96000);
      3'd2:    p = PERIOD_WIDTH'(48000);
      3'd3:    p = PERIOD_WIDTH'(24000);
      3'd4:    p = PERIOD_WIDTH'(8000);
      3'd5:    p = PERIOD_WIDTH'(4000);
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/stepper_target_step_generator.sv @@
// step and direction generator moving a position counter toward a target
//
// Each input transaction is one request (a microsecond tick, start, stop, set target,
// set position or set continuous mode) and yields exactly one result transaction. The
// whole update is done in the cycle the request is taken and lands in the output
// register, so a request can be accepted in every clock cycle; the only wait comes
// from the output side holding a result (in_ready is low while out_valid is high and
// out_ready is low). Configuration writes are taken in any cycle (cfg_ready is always
// high) and should only be issued while no request is outstanding.
module stepper_target_step_generator
  import stg_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [REQ_WIDTH-1:0]              req_type,
  input  logic signed [OPERAND_WIDTH-1:0]   operand_value,
  input  logic                              cont_enable,
  input  logic                              cont_dir,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              step_pulse,
  output logic                              dir_level,
  output logic                              moving,
  output logic signed [OUT_POS_WIDTH-1:0]   position,
  output logic                              move_done,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]         cfg_value
);

  logic [SPEED_WIDTH-1:0]        speed_mode;
  logic [USTEP_WIDTH-1:0]        microstep_log2;
  logic                          reverse_direction;

  logic signed [POS_WIDTH-1:0]   pos_count, pos_count_next;
  logic signed [POS_WIDTH-1:0]   target_pos, target_pos_next;
  logic                          moving_flag, moving_flag_next;
  logic                          cont_mode, cont_mode_next;
  logic                          cont_direction, cont_direction_next;
  logic [PERIOD_WIDTH-1:0]       period_reload, period_reload_next;
  logic [PERIOD_WIDTH-1:0]       period_count, period_count_next;
  logic                          dir_pin, dir_pin_next;
  logic                          step_next, done_next;

  logic                          in_fire;
  logic signed [POS_WIDTH-1:0]   pos_up, pos_down, tgt_eff;
  logic signed [EXT_WIDTH-1:0]   pos_ext;

  assign in_ready = !out_valid || out_ready;
  assign in_fire = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign pos_up = pos_count + POS_ONE;
  assign pos_down = pos_count - POS_ONE;
  assign tgt_eff = cont_mode ? (cont_direction ? pos_up : pos_down) : target_pos;
  assign pos_ext = EXT_WIDTH'(pos_count_next);

  always_comb begin
    pos_count_next = pos_count;
    target_pos_next = target_pos;
    moving_flag_next = moving_flag;
    cont_mode_next = cont_mode;
    cont_direction_next = cont_direction;
    period_reload_next = period_reload;
    period_count_next = period_count;
    dir_pin_next = dir_pin;
    step_next = 1'b0;
    done_next = 1'b0;
    if (in_fire) begin
      case (req_type)
        REQ_TICK: begin
          if (moving_flag) begin
            if (period_count > PERIOD_ONE) begin
              period_count_next = period_count - PERIOD_ONE;
            end else begin
              period_count_next = period_reload;
              target_pos_next = tgt_eff;
              if (tgt_eff < pos_count) begin
                dir_pin_next = reverse_direction;
                pos_count_next = pos_down;
                step_next = 1'b1;
              end else if (pos_count < tgt_eff) begin
                dir_pin_next = !reverse_direction;
                pos_count_next = pos_up;
                step_next = 1'b1;
              end else begin
                moving_flag_next = 1'b0;
                target_pos_next = pos_count;
                done_next = 1'b1;
              end
            end
          end
        end
        REQ_START: begin
          if (speed_mode >= SPEED_MIN && speed_mode <= SPEED_MAX) begin
            period_reload_next = base_period(speed_mode) >> microstep_log2;
          end
          if (!moving_flag) begin
            period_count_next = '0;
          end
          moving_flag_next = 1'b1;
        end
        REQ_STOP: begin
          done_next = moving_flag;
          moving_flag_next = 1'b0;
          target_pos_next = pos_count;
        end
        REQ_SET_TARGET: target_pos_next = POS_WIDTH'(operand_value);
        REQ_SET_POS: pos_count_next = POS_WIDTH'(operand_value);
        REQ_SET_CONT: begin
          cont_mode_next = cont_enable;
          cont_direction_next = cont_dir;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_mode <= SPEED_RESET;
      microstep_log2 <= '0;
      reverse_direction <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SPEED_MODE: speed_mode <= cfg_value[SPEED_WIDTH-1:0];
        CFG_MICROSTEP:  microstep_log2 <= cfg_value[USTEP_WIDTH-1:0];
        CFG_REVERSE:    reverse_direction <= cfg_value[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_count <= '0;
      target_pos <= '0;
      moving_flag <= 1'b0;
      cont_mode <= 1'b0;
      cont_direction <= 1'b0;
      period_reload <= PERIOD_RESET;
      period_count <= '0;
      dir_pin <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pos_count <= pos_count_next;
      target_pos <= target_pos_next;
      moving_flag <= moving_flag_next;
      cont_mode <= cont_mode_next;
      cont_direction <= cont_direction_next;
      period_reload <= period_reload_next;
      period_count <= period_count_next;
      dir_pin <= dir_pin_next;
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      step_pulse <= step_next;
      dir_level <= dir_pin_next;
      moving <= moving_flag_next;
      position <= pos_ext[OUT_POS_WIDTH-1:0];
      move_done <= done_next;
    end
  end

  a_step_xor_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(step_pulse && move_done))
    else $error("step and move done in the same transaction");

  a_done_not_moving: assert property (@(posedge clk) disable iff (rst)
    (out_valid && move_done) |-> !moving)
    else $error("move done while still moving");

  a_step_moving: assert property (@(posedge clk) disable iff (rst)
    (out_valid && step_pulse) |-> moving)
    else $error("step issued without a move");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && req_type == REQ_STOP) |=> (out_valid && !moving && !step_pulse))
    else $error("stop did not end the move");

endmodule
